@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RLNP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RLNP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Same-cycle implication that is also checked during reset.
`define RLNP_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/rlnp_pkg.sv @@
// Types, codes and a helper function of the RESP line number parser.
`timescale 1ns / 1ps

package rlnp_pkg;

  localparam int BYTE_W   = 8;
  localparam int TYPE_W   = 3;
  localparam int STATUS_W = 3;
  localparam int NUM_W    = 64;
  localparam int WIDE_W   = NUM_W + 4;
  localparam int OUT_W    = 72;

  // Line type codes.
  localparam logic [TYPE_W-1:0] TYPE_ERROR   = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_SIMPLE  = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_INTEGER = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_BULK    = 3'd3;
  localparam logic [TYPE_W-1:0] TYPE_ARRAY   = 3'd4;
  localparam logic [TYPE_W-1:0] TYPE_UNKNOWN = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FRAMING  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_NUM  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 3'd4;

  // Number phase codes.
  localparam logic [1:0] PH_EMPTY  = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  // Characters.
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  localparam logic [NUM_W-1:0] MAX_MAG = {1'b0, {(NUM_W-1){1'b1}}};

  typedef struct packed {
    logic [BYTE_W-1:0] line_byte;
    logic              line_end;
  } rlnp_item_t;

  function automatic logic [TYPE_W-1:0] prefix_kind(input logic [BYTE_W-1:0] c);
    logic [TYPE_W-1:0] k;
    case (c)
      CH_MINUS:  k = TYPE_ERROR;
      CH_PLUS:   k = TYPE_SIMPLE;
      CH_COLON:  k = TYPE_INTEGER;
      CH_DOLLAR: k = TYPE_BULK;
      CH_STAR:   k = TYPE_ARRAY;
      default:   k = TYPE_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

@@ sv/resp_line_number_parser.sv @@
// Results are registered at the output and wait there while further bytes flow in.
// Throughput: one byte per cycle, save that a line's last byte stalls while a
// result is untaken; the accumulate-and-compare step on each byte is one 68-bit
// shift-add and compare between the input and state registers.
// Reset (rst, synchronous) empties both registers and starts a new line.
`timescale 1ns / 1ps

module resp_line_number_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] line_byte
  input  logic        s_axis_tlast,   // line_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // [2:0] line_type, [5:3] status, [69:6] number
);
  import rlnp_pkg::*;

  logic       item_valid;
  rlnp_item_t item;
  logic       consume;

  rlnp_in_stage u_in_stage (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .item_valid    (item_valid),
    .item          (item),
    .consume       (consume)
  );

  rlnp_line_core u_line_core (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item          (item),
    .consume       (consume),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

@@ sv/rlnp_in_stage.sv @@
// Input register of the RESP line number parser.
`timescale 1ns / 1ps

module rlnp_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,
  input  logic               s_axis_tlast,
  output logic               item_valid,
  output rlnp_pkg::rlnp_item_t item,
  input  logic               consume
);
  import rlnp_pkg::*;

  // The register refills in the same cycle that the core takes its contents.
  assign s_axis_tready = !item_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.line_byte <= s_axis_tdata;
      item.line_end  <= s_axis_tlast;
    end
  end

endmodule

@@ sv/rlnp_line_core.sv @@
// Line state, number accumulator and result register of the parser.
`timescale 1ns / 1ps

module rlnp_line_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  rlnp_pkg::rlnp_item_t item,
  output logic                 consume,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [71:0]          m_axis_tdata
);
  import rlnp_pkg::*;

  logic [TYPE_W-1:0] kind, kind_next;
  logic [1:0]        cnt, cnt_next;
  logic [BYTE_W-1:0] held0, held0_next, held1, held1_next;
  logic              neg, neg_next;
  logic [1:0]        phase, phase_next;
  logic [NUM_W-1:0]  mag, mag_next;
  logic              bad, bad_next;

  logic [BYTE_W-1:0] feed_byte;
  logic [3:0]        digit;
  logic [WIDE_W-1:0] wide_mag, acc, limit;
  logic              overflow;

  logic [TYPE_W-1:0]   res_type;
  logic [STATUS_W-1:0] res_status;
  logic [NUM_W-1:0]    res_number;
  logic                finish;

  assign consume = item_valid && (!item.line_end || !m_axis_tvalid || m_axis_tready);
  assign finish  = consume && item.line_end;

  // The byte entering the number is the oldest held byte; the newest two are
  // kept back until the line ends, since they may be the closing CR LF.
  assign feed_byte = held0;
  assign digit     = 4'(feed_byte - CH_ZERO);
  assign wide_mag  = {4'b0, mag};
  assign acc       = (wide_mag << 3) + (wide_mag << 1) + WIDE_W'(digit);
  assign limit     = {4'b0, MAX_MAG} + WIDE_W'(neg);
  assign overflow  = acc > limit;

  always_comb begin
    kind_next  = kind;
    cnt_next   = cnt;
    held0_next = held0;
    held1_next = held1;
    neg_next   = neg;
    phase_next = phase;
    mag_next   = mag;
    bad_next   = bad;
    case (cnt)
      2'd0: begin
        kind_next = prefix_kind(item.line_byte);
        cnt_next  = 2'd1;
      end
      2'd1: begin
        held0_next = item.line_byte;
        cnt_next   = 2'd2;
      end
      2'd2: begin
        held1_next = item.line_byte;
        cnt_next   = 2'd3;
      end
      default: begin
        held0_next = held1;
        held1_next = item.line_byte;
        if (!bad) begin
          if (phase == PH_EMPTY && (feed_byte == CH_MINUS || feed_byte == CH_PLUS)) begin
            neg_next   = (feed_byte == CH_MINUS);
            phase_next = PH_SIGN;
          end else if (!(feed_byte inside {[CH_ZERO:CH_NINE]})) begin
            bad_next = 1'b1;
          end else if (overflow) begin
            bad_next = 1'b1;
          end else begin
            mag_next   = acc[NUM_W-1:0];
            phase_next = PH_DIGITS;
          end
        end
      end
    endcase
  end

  always_comb begin
    res_type   = kind_next;
    res_number = '0;
    if (kind_next == TYPE_UNKNOWN) begin
      res_status = ST_UNKNOWN;
    end else if (cnt_next != 2'd3 || held0_next != CH_CR || held1_next != CH_LF) begin
      res_status = ST_FRAMING;
    end else if (kind_next == TYPE_ERROR || kind_next == TYPE_SIMPLE) begin
      res_status = ST_OK;
    end else if (bad_next || phase_next != PH_DIGITS) begin
      res_status = ST_BAD_NUM;
    end else if (kind_next != TYPE_INTEGER && neg_next && mag_next > NUM_W'(1)) begin
      res_status = ST_BAD_LEN;
    end else begin
      res_status = ST_OK;
      res_number = neg_next ? (~mag_next + NUM_W'(1)) : mag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || finish) begin
      kind  <= TYPE_ERROR;
      cnt   <= 2'd0;
      neg   <= 1'b0;
      phase <= PH_EMPTY;
      mag   <= '0;
      bad   <= 1'b0;
    end else if (consume) begin
      kind  <= kind_next;
      cnt   <= cnt_next;
      neg   <= neg_next;
      phase <= phase_next;
      mag   <= mag_next;
      bad   <= bad_next;
    end
  end

  // Held bytes are only read once the count shows both were written.
  always_ff @(posedge clk) begin
    if (consume) begin
      held0 <= held0_next;
      held1 <= held1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_axis_tdata <= {2'b00, res_number, res_status, res_type};
    end
  end

endmodule

@@ sv/rlnp_checker.sv @@
// Port-level checks of the RESP line number parser and their binding.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rlnp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  import rlnp_pkg::*;

  logic [TYPE_W-1:0]   out_type;
  logic [STATUS_W-1:0] out_status;
  logic [NUM_W-1:0]    out_number;
  logic                out_stall;
  logic                status_unknown;
  logic                type_unknown;
  logic                len_kind;

  assign out_type       = m_axis_tdata[2:0];
  assign out_status     = m_axis_tdata[5:3];
  assign out_number     = m_axis_tdata[69:6];
  assign out_stall      = m_axis_tvalid && !m_axis_tready;
  assign status_unknown = (out_status == ST_UNKNOWN);
  assign type_unknown   = (out_type == TYPE_UNKNOWN);
  assign len_kind       = (out_type == TYPE_BULK) || (out_type == TYPE_ARRAY);

  // A stalled result transaction keeps its contents.
  `RLNP_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // A failed line never carries a number.
  `RLNP_ASSERT_IMPL(a_fail_zero, clk, rst, m_axis_tvalid && out_status != ST_OK, out_number == '0)

  // The unknown-prefix status goes with the unknown type and nothing else.
  `RLNP_ASSERT_IMPL(a_unknown_pair, clk, rst, m_axis_tvalid, status_unknown == type_unknown)

  // Only bulk and array lines can be rejected for a short length.
  `RLNP_ASSERT_IMPL(a_len_kind, clk, rst, m_axis_tvalid && out_status == ST_BAD_LEN, len_kind)

  // No result is offered in the first cycle after reset is released.
  `RLNP_ASSERT_ALWAYS(a_reset_empty, clk, !rst && $past(rst), !m_axis_tvalid)

endmodule

bind resp_line_number_parser rlnp_checker u_rlnp_checker (.*);
